// ===== src/sgmpca_pkg.sv =====
// Shared types and constants of the SGM path cost aggregation block.
package sgmpca_pkg;

  localparam int NUM_DISP = 64;
  localparam int DISP_W   = $clog2(NUM_DISP);
  localparam int COUNT_W  = $clog2(NUM_DISP + 1);
  localparam int COST_W   = 13;
  localparam int AGG_W    = 14;
  localparam int P1_W     = 10;
  localparam int P2_W     = 12;
  localparam int CFG_W    = 12;
  localparam int CFG_IDX_W = 2;
  localparam int TERM_W   = AGG_W + 1;   // previous aggregate plus a penalty
  localparam int SUM_W    = TERM_W + 1;  // matching cost plus the minimum term

  localparam logic [AGG_W-1:0]   AGG_MAX     = {AGG_W{1'b1}};
  localparam logic [P1_W-1:0]    P1_RESET    = P1_W'(10);
  localparam logic [P2_W-1:0]    P2_RESET    = P2_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(NUM_DISP);
  localparam logic [COUNT_W-1:0] COUNT_MIN   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(NUM_DISP);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P1    = 2'd0,
    CFG_P2    = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [COST_W-1:0] cost_value;
    logic              path_start;
  } in_t;

  typedef struct packed {
    logic [AGG_W-1:0]  aggregated_cost;
    logic [DISP_W-1:0] disparity_index;
    logic              pixel_done;
    logic [AGG_W-1:0]  pixel_minimum;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [DISP_W-1:0] addr;
    logic [AGG_W-1:0]  data;
  } mem_wr_t;

endpackage

// ===== src/sgmpca_vec_mem.sv =====
// Previous-pixel aggregate memory with two registered read ports and write bypass.
module sgmpca_vec_mem (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sgmpca_pkg::mem_wr_t              wr,
  input  logic [sgmpca_pkg::DISP_W-1:0]    raddr_a,
  input  logic [sgmpca_pkg::DISP_W-1:0]    raddr_b,
  output logic [sgmpca_pkg::AGG_W-1:0]     rdata_a,
  output logic [sgmpca_pkg::AGG_W-1:0]     rdata_b
);
  import sgmpca_pkg::*;

  logic [AGG_W-1:0] mem_r [NUM_DISP];
  logic [AGG_W-1:0] rd_a_r, rd_b_r, byp_data_r;
  logic             byp_a_r, byp_b_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_a_r     <= mem_r[raddr_a];
    rd_b_r     <= mem_r[raddr_b];
    byp_data_r <= wr.data;
  end

  // A read that meets a write to the same entry at the same edge takes the new data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      byp_a_r <= wr.en && (wr.addr == raddr_a);
      byp_b_r <= wr.en && (wr.addr == raddr_b);
    end
  end

  assign rdata_a = byp_a_r ? byp_data_r : rd_a_r;
  assign rdata_b = byp_b_r ? byp_data_r : rd_b_r;

endmodule

// ===== src/sgm_path_cost_aggregation_top.sv =====
// Top level of the SGM path cost aggregation block.
// A result is registered in the output register, or in the skid stage while the output is held.
// Throughput: one disparity per cycle while the skid stage is empty, set by the read-modify-write
// of the previous-pixel memory, whose reads run one transfer ahead of use.
// Reset (rst_n low, synchronous) restores the penalty and count registers and
// marks the next pixel as a path start; the aggregate memory is not cleared.
module sgm_path_cost_aggregation_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sgmpca_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output sgmpca_pkg::out_t                   out_data,
  input  logic                               cfg_we,
  input  logic [sgmpca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sgmpca_pkg::CFG_W-1:0]       cfg_wdata
);
  import sgmpca_pkg::*;

  // Configuration registers.
  logic [P1_W-1:0]    p1_r;
  logic [P2_W-1:0]    p2_r;
  logic [COUNT_W-1:0] count_r;

  // Per-path state held outside the memory.
  logic [DISP_W-1:0] cnt_r, cnt_nxt;
  logic              at_start_r;
  logic [AGG_W-1:0]  prev_min_r;
  logic [AGG_W-1:0]  run_min_r;
  logic [AGG_W-1:0]  held_left_r;

  // Output register and skid stage.
  logic out_valid_r, skid_valid_r;
  out_t out_data_r, skid_data_r;

  logic              accept;
  logic [COUNT_W-1:0] count_use;
  logic              first, last, start_eff;
  logic [AGG_W-1:0]  here, rd_right, left, right;
  logic [TERM_W-1:0] t_here, t_left, t_right, t_jump, m01, m23, m_min;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  diff;
  logic [AGG_W-1:0]  agg, run_new;
  out_t              result;
  mem_wr_t           wr;

  assign accept   = in_valid && in_ready;
  assign in_ready = !skid_valid_r;

  // The count register is used as if clamped to the supported range.
  always_comb begin
    count_use = count_r;
    if (count_r < COUNT_MIN) count_use = COUNT_MIN;
    if (count_r > COUNT_MAX) count_use = COUNT_MAX;
  end

  assign first     = (cnt_r == '0);
  assign last      = ({1'b0, cnt_r} >= (count_use - COUNT_W'(1)));
  assign start_eff = at_start_r || (first && in_data.path_start);

  // The memory reads the entries of the next expected disparity and its right
  // neighbor, so both are ready in the cycle that the transfer arrives.
  sgmpca_vec_mem u_vec_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .raddr_a (cnt_nxt),
    .raddr_b (cnt_nxt + DISP_W'(1)),
    .rdata_a (here),
    .rdata_b (rd_right)
  );

  // At disparity zero the left neighbor clamps to entry zero; on the last
  // disparity the right neighbor clamps to the entry itself.
  assign left  = first ? here : held_left_r;
  assign right = last ? here : rd_right;

  always_comb begin
    t_here  = TERM_W'(here);
    t_left  = TERM_W'(left) + TERM_W'(p1_r);
    t_right = TERM_W'(right) + TERM_W'(p1_r);
    t_jump  = TERM_W'(prev_min_r) + TERM_W'(p2_r);
    m01     = (t_left < t_here) ? t_left : t_here;
    m23     = (t_jump < t_right) ? t_jump : t_right;
    m_min   = (m23 < m01) ? m23 : m01;
    sum     = SUM_W'(in_data.cost_value) + SUM_W'(m_min);
    // A minimum term below the previous minimum only follows a count change;
    // the difference then counts as zero.
    diff    = (sum < SUM_W'(prev_min_r)) ? '0 : (sum - SUM_W'(prev_min_r));
    if (start_eff) begin
      agg = AGG_W'(in_data.cost_value);
    end else if (diff > SUM_W'(AGG_MAX)) begin
      agg = AGG_MAX;
    end else begin
      agg = diff[AGG_W-1:0];
    end
    run_new = (first || (agg < run_min_r)) ? agg : run_min_r;
  end

  always_comb begin
    result.aggregated_cost = agg;
    result.disparity_index = cnt_r;
    result.pixel_done      = last;
    result.pixel_minimum   = last ? run_new : '0;
  end

  assign wr.en   = accept;
  assign wr.addr = cnt_r;
  assign wr.data = agg;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = last ? '0 : (cnt_r + DISP_W'(1));
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r    <= P1_RESET;
      p2_r    <= P2_RESET;
      count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_P1:    p1_r    <= cfg_wdata[P1_W-1:0];
        CFG_P2:    p2_r    <= cfg_wdata[P2_W-1:0];
        CFG_COUNT: count_r <= cfg_wdata[COUNT_W-1:0];
        default:   ;
      endcase
    end
  end

  // Path state update on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      at_start_r  <= 1'b1;
      prev_min_r  <= '0;
      run_min_r   <= AGG_MAX;
      held_left_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        held_left_r <= here;
        if (last) begin
          prev_min_r <= run_new;
          run_min_r  <= AGG_MAX;
          at_start_r <= 1'b0;
        end else begin
          run_min_r  <= run_new;
          at_start_r <= start_eff;
        end
      end
    end
  end

  // Output register with a one-entry skid stage: a new transfer is taken while
  // a finished result is still waiting at the output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The skid stage only fills behind a held output result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a result while the output register is empty");

  // A transfer that is not the last of its pixel advances the disparity by one.
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !last) |=> (cnt_r == DISP_W'($past(cnt_r) + DISP_W'(1))))
    else $error("disparity counter did not advance by one");

  // The last disparity closes the pixel and ends any path start.
  a_pixel_close: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && last) |=> ((cnt_r == '0) && !at_start_r && (run_min_r == AGG_MAX)))
    else $error("pixel state not restarted after the last disparity");

  // A result that reaches the output register is offered at the next cycle.
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (out_ready || !out_valid_r) && !skid_valid_r) |=> out_valid_r)
    else $error("accepted transfer produced no output result");

endmodule
